@@ rtl/core/playfield_row_dedup_encoder_macros.svh @@
// ---------------------------------------------------------------------------
// playfield_row_dedup_encoder_macros.svh
// Assertion macros used by the checker file pfdd_checker.
// ---------------------------------------------------------------------------
`ifndef PLAYFIELD_ROW_DEDUP_ENCODER_MACROS_SVH
`define PLAYFIELD_ROW_DEDUP_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFDD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pfdd_pkg.sv @@
// ---------------------------------------------------------------------------
// pfdd_pkg
// Shared types, constants and helpers of the playfield row dedup encoder.
// ---------------------------------------------------------------------------
package pfdd_pkg;

    localparam int DICT_DEPTH_DEF = 256;
    localparam int HALF_WIDTH     = 20;
    localparam int FULL_WIDTH     = 2 * HALF_WIDTH;
    localparam int COL_W          = 9;
    localparam logic [COL_W-1:0] COL_MAX = 9'd511;
    localparam int PAL_OFFSET     = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_BG_COLOR   = 2'd0;
    localparam logic [1:0] CFG_BG_FIRST   = 2'd1;
    localparam logic [1:0] CFG_PAL_MODE   = 2'd2;
    localparam logic [1:0] CFG_SKIP_LOG2  = 2'd3;

    typedef logic [FULL_WIDTH-1:0] mask_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pfdd_ram.sv @@
// ---------------------------------------------------------------------------
// pfdd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module pfdd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/playfield_row_dedup_encoder.sv @@
// ---------------------------------------------------------------------------
// playfield_row_dedup_encoder
// Builds per-row playfield masks from palette pixels and dedups them.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one pixel per transfer (valid/ready), left to right, with
//   s_row_end on the last pixel of a row and s_frame_start on the first pixel
//   of a frame (clears dictionary, row count and the partial row).
//   m_* channel: one result per selected row, on valid/ready.
//   cfg_*: plain write port, takes effect at the clock edge; write only idle.
// Timing:
//   Pixels that do not end a selected row are taken one per cycle, back to back.
//   A selected row end runs a linear search of the pattern RAM, one entry per
//   cycle, stopping early on a hit; the result then goes to the output
//   register. s_ready is low meanwhile. The search reads a RAM with one
//   registered read port.
// Stall:
//   The result sits in an output register; pixels keep flowing while it
//   waits. Only a second result waits for m_ready before the block resumes.
// Reset:
//   aresetn (sync, active low) clears the control and config registers, counters and the
//   dictionary fill count. The pattern RAM needs no clearing pass.
// ---------------------------------------------------------------------------
module playfield_row_dedup_encoder #(
    parameter int DICT_DEPTH = pfdd_pkg::DICT_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_index,
    input  logic [7:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pixel,
    input  logic       s_row_end,
    input  logic       s_frame_start,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_row_index,
    output logic [8:0] m_line_color,
    output logic [8:0] m_line_background,
    output logic [7:0] m_pf0_left,
    output logic [7:0] m_pf1_left,
    output logic [7:0] m_pf2_left,
    output logic [7:0] m_pf0_right,
    output logic [7:0] m_pf1_right,
    output logic [7:0] m_pf2_right,
    output logic [7:0] m_entry_index,
    output logic       m_new_entry,
    output logic       m_dict_full
);

    localparam int AW = $clog2(DICT_DEPTH);        // RAM address width
    localparam int CW = $clog2(DICT_DEPTH + 1);    // fill count width
    localparam int SW = (AW > 8) ? AW : 8;         // slot widened for output
    localparam int FW = pfdd_pkg::FULL_WIDTH;
    localparam int HW = pfdd_pkg::HALF_WIDTH;
    localparam int CLW = pfdd_pkg::COL_W;

    // configuration
    logic [7:0] cfg_bg_color_reg;
    logic       cfg_bg_first_reg;
    logic       cfg_pal_reg;
    logic [1:0] cfg_skip_reg;

    // control / row state
    pfdd_pkg::state_t state_reg, state_next;
    logic [CLW-1:0]  col_reg, col_next;
    logic [7:0]      row_reg, row_next;
    pfdd_pkg::mask_t mask_reg, mask_next;
    logic [7:0]      color_reg, color_next;
    logic [7:0]      bg_reg, bg_next;
    logic [CW-1:0]   entry_count_reg, entry_count_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic            m_valid_reg, m_valid_next;

    // captured row under search (payload)
    pfdd_pkg::mask_t res_mask_reg;
    logic [7:0]      res_color_reg, res_bg_reg, res_row_reg;
    logic [AW-1:0]   cmp_idx_reg;
    logic [AW-1:0]   slot_reg;
    logic            new_reg, full_reg;
    logic            capture, decide;
    logic [AW-1:0]   slot_next;
    logic            new_next, full_next;

    // output payload registers
    logic [7:0] out_row_reg;
    logic [8:0] out_color_reg, out_bg_reg;
    logic [7:0] out_pf0l_reg, out_pf1l_reg, out_pf2l_reg;
    logic [7:0] out_pf0r_reg, out_pf1r_reg, out_pf2r_reg;
    logic [7:0] out_idx_reg;
    logic       out_new_reg, out_full_reg;
    logic       load_out;

    // pixel datapath
    logic            accept;
    logic [CLW-1:0]  col_cur;
    logic [7:0]      row_cur, color_cur, bg_cur, bg_eff, color_upd;
    pfdd_pkg::mask_t mask_cur, mask_upd;
    logic            fg;
    logic [7:0]      skip_mask;
    logic            selected;

    // RAM
    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    pfdd_pkg::mask_t     ram_rd_data;
    logic                issuing, hit, miss_done;
    logic [SW-1:0]       slot_wide;
    logic [8:0]          pal_add;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == pfdd_pkg::ST_ACCUM);

    // frame start drops the partial row before the pixel counts
    assign col_cur   = s_frame_start ? '0 : col_reg;
    assign row_cur   = s_frame_start ? '0 : row_reg;
    assign mask_cur  = s_frame_start ? '0 : mask_reg;
    assign color_cur = s_frame_start ? '0 : color_reg;
    assign bg_cur    = s_frame_start ? '0 : bg_reg;

    assign bg_eff    = (col_cur == '0) ? (cfg_bg_first_reg ? s_pixel : cfg_bg_color_reg)
                                       : bg_cur;
    assign fg        = (s_pixel != bg_eff);
    assign color_upd = fg ? s_pixel : color_cur;

    // leftmost pixel lands in the top mask bit
    always_comb begin
        for (int k = 0; k < FW; k++) begin
            mask_upd[FW-1-k] = mask_cur[FW-1-k] || (fg && (col_cur == CLW'(k)));
        end
    end

    assign skip_mask = (8'd1 << cfg_skip_reg) - 8'd1;
    assign selected  = ((row_cur & skip_mask) == 8'd0);

    // search pipeline: issue one read per cycle, compare the data next cycle
    assign issuing   = (issue_reg < entry_count_reg);
    assign hit       = cmp_vld_reg && (ram_rd_data == res_mask_reg);
    assign miss_done = !issuing && !cmp_vld_reg;

    assign load_out  = (state_reg == pfdd_pkg::ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        mask_next        = mask_reg;
        color_next       = color_reg;
        bg_next          = bg_reg;
        entry_count_next = entry_count_reg;
        issue_next       = issue_reg;
        cmp_vld_next     = 1'b0;
        capture          = 1'b0;
        decide           = 1'b0;
        slot_next        = slot_reg;
        new_next         = 1'b0;
        full_next        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_wr_en        = 1'b0;

        unique case (state_reg)
            pfdd_pkg::ST_ACCUM: begin
                if (accept) begin
                    if (s_frame_start) begin
                        entry_count_next = '0;
                    end
                    if (s_row_end) begin
                        row_next   = row_cur + 8'd1;
                        col_next   = '0;
                        mask_next  = '0;
                        color_next = '0;
                        bg_next    = '0;
                        if (selected) begin
                            capture    = 1'b1;
                            issue_next = '0;
                            state_next = pfdd_pkg::ST_SEARCH;
                        end
                    end else begin
                        row_next   = row_cur;
                        col_next   = (col_cur < pfdd_pkg::COL_MAX) ? col_cur + 1'b1 : col_cur;
                        mask_next  = mask_upd;
                        color_next = color_upd;
                        bg_next    = bg_eff;
                    end
                end
            end
            pfdd_pkg::ST_SEARCH: begin
                if (hit) begin
                    decide     = 1'b1;
                    slot_next  = cmp_idx_reg;
                    state_next = pfdd_pkg::ST_FINISH;
                end else if (miss_done) begin
                    decide     = 1'b1;
                    state_next = pfdd_pkg::ST_FINISH;
                    if (entry_count_reg < CW'(DICT_DEPTH)) begin
                        ram_wr_en        = 1'b1;
                        slot_next        = entry_count_reg[AW-1:0];
                        new_next         = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                    end else begin
                        slot_next = '0;
                        full_next = 1'b1;
                    end
                end else begin
                    ram_rd_en    = issuing;
                    cmp_vld_next = issuing;
                    if (issuing) begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end
            pfdd_pkg::ST_FINISH: begin
                if (load_out) begin
                    state_next = pfdd_pkg::ST_ACCUM;
                end
            end
            default: state_next = pfdd_pkg::ST_ACCUM;
        endcase
    end

    assign ram_rd_addr = issue_reg[AW-1:0];
    assign ram_wr_addr = entry_count_reg[AW-1:0];

    assign m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // control state, config, row accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= pfdd_pkg::ST_ACCUM;
            col_reg          <= '0;
            row_reg          <= '0;
            mask_reg         <= '0;
            color_reg        <= '0;
            bg_reg           <= '0;
            entry_count_reg  <= '0;
            issue_reg        <= '0;
            cmp_vld_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            cfg_bg_color_reg <= '0;
            cfg_bg_first_reg <= 1'b0;
            cfg_pal_reg      <= 1'b0;
            cfg_skip_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            mask_reg        <= mask_next;
            color_reg       <= color_next;
            bg_reg          <= bg_next;
            entry_count_reg <= entry_count_next;
            issue_reg       <= issue_next;
            cmp_vld_reg     <= cmp_vld_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    pfdd_pkg::CFG_BG_COLOR:  cfg_bg_color_reg <= cfg_wr_data;
                    pfdd_pkg::CFG_BG_FIRST:  cfg_bg_first_reg <= cfg_wr_data[0];
                    pfdd_pkg::CFG_PAL_MODE:  cfg_pal_reg      <= cfg_wr_data[0];
                    pfdd_pkg::CFG_SKIP_LOG2: cfg_skip_reg     <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload: captured row, search result, output register
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= issue_reg[AW-1:0];
        if (capture) begin
            res_mask_reg  <= mask_upd;
            res_color_reg <= color_upd;
            res_bg_reg    <= bg_eff;
            res_row_reg   <= row_cur;
        end
        if (decide) begin
            slot_reg <= slot_next;
            new_reg  <= new_next;
            full_reg <= full_next;
        end
        if (load_out) begin
            out_row_reg   <= res_row_reg;
            out_color_reg <= {1'b0, res_color_reg} + pal_add;
            out_bg_reg    <= {1'b0, res_bg_reg} + pal_add;
            out_pf0l_reg  <= pfdd_pkg::flip8({4'd0, res_mask_reg[FW-1 -: 4]});
            out_pf1l_reg  <= res_mask_reg[FW-5 -: 8];
            out_pf2l_reg  <= pfdd_pkg::flip8(res_mask_reg[HW +: 8]);
            out_pf0r_reg  <= pfdd_pkg::flip8({4'd0, res_mask_reg[HW-1 -: 4]});
            out_pf1r_reg  <= res_mask_reg[HW-5 -: 8];
            out_pf2r_reg  <= pfdd_pkg::flip8(res_mask_reg[7:0]);
            out_idx_reg   <= slot_wide[7:0];
            out_new_reg   <= new_reg;
            out_full_reg  <= full_reg;
        end
    end

    assign pal_add   = cfg_pal_reg ? 9'(pfdd_pkg::PAL_OFFSET) : 9'd0;
    assign slot_wide = SW'(slot_reg);

    pfdd_ram #(
        .WIDTH (FW),
        .DEPTH (DICT_DEPTH)
    ) u_pattern_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (res_mask_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_valid           = m_valid_reg;
    assign m_row_index       = out_row_reg;
    assign m_line_color      = out_color_reg;
    assign m_line_background = out_bg_reg;
    assign m_pf0_left        = out_pf0l_reg;
    assign m_pf1_left        = out_pf1l_reg;
    assign m_pf2_left        = out_pf2l_reg;
    assign m_pf0_right       = out_pf0r_reg;
    assign m_pf1_right       = out_pf1r_reg;
    assign m_pf2_right       = out_pf2r_reg;
    assign m_entry_index     = out_idx_reg;
    assign m_new_entry       = out_new_reg;
    assign m_dict_full       = out_full_reg;

endmodule

@@ rtl/core/pfdd_checker.sv @@
// ---------------------------------------------------------------------------
// pfdd_checker
// Port-level checks of the playfield row dedup encoder, bound to the top.
// ---------------------------------------------------------------------------
`include "playfield_row_dedup_encoder_macros.svh"

module pfdd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_row_index,
    input logic [7:0] m_pf0_left,
    input logic [7:0] m_pf0_right,
    input logic [7:0] m_entry_index,
    input logic       m_new_entry,
    input logic       m_dict_full
);

    // a stalled result holds
    `PFDD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_row_index) && $stable(m_entry_index), "result changed under stall")

    // a pattern is either inserted, found, or rejected for lack of room
    `PFDD_ASSERT_SAME(a_new_xor_full, aclk, aresetn, m_valid,
        !(m_new_entry && m_dict_full), "new_entry and dict_full together")

    // a rejected pattern reports slot zero
    `PFDD_ASSERT_SAME(a_full_slot, aclk, aresetn, m_valid && m_dict_full,
        m_entry_index == 8'd0, "dict_full with nonzero slot")

    // PF0 carries only four pixels, in its high nibble
    `PFDD_ASSERT_SAME(a_pf0_nibble, aclk, aresetn, m_valid,
        (m_pf0_left[3:0] == 4'd0) && (m_pf0_right[3:0] == 4'd0), "PF0 low nibble set")

endmodule

bind playfield_row_dedup_encoder pfdd_checker u_pfdd_checker (.*);
